// ----- hdl/iqlr_pkg.sv -----
package iqlr_pkg;

  // block geometry
  localparam int OUT_BLOCK  = 2048;
  localparam int FRAC_BITS  = 11;
  localparam int MAX_IN_LEN = 8192;

  // field and state widths
  localparam int SAMPLE_W = 32;
  localparam int LEN_W    = 14;
  localparam int OIDX_W   = 11;
  localparam int ACC_W    = 25;
  localparam int CFG_W    = 14;

  // configuration register indexes
  typedef enum logic [0:0] {
    REG_IQ_SWAP      = 1'b0,
    REG_IN_BLOCK_LEN = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] first_word;
    logic signed [SAMPLE_W-1:0] second_word;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] out_real;
    logic signed [SAMPLE_W-1:0] out_imag;
    logic                       block_last;
  } out_item_t;

endpackage

// ----- hdl/iq_linear_resampler.sv -----
// channel  | direction | handshake            | payload
// ---------+-----------+----------------------+-------------------------------
// in       | input     | in_valid / in_ready  | in_data  (first_word, second_word)
// out      | output    | out_valid / out_ready| out_data (out_real, out_imag, block_last)
// cfg      | input     | cfg_wr_en            | cfg_index, cfg_data
//
// one input transaction per cycle while in_ready is high; the result for the
// transaction that completes its sample pair passes through the interpolation
// stage, then the multiply-add into the output register
// synchronous reset clears the block counters, the previous sample and the
// configuration (iq_swap 0, in_block_len 3072)
// with out_ready low the output register holds and the interpolation stage
// still takes one more transaction; in_ready falls only when both are full
module iq_linear_resampler
  import iqlr_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_item_t             in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_item_t            out_data,
  input  logic                 cfg_wr_en,
  input  cfg_reg_t             cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  localparam int DIFF_W = SAMPLE_W + 1;
  localparam int PROD_W = DIFF_W + FRAC_BITS + 1;
  localparam int BASE_W = ACC_W - FRAC_BITS;

  // configuration
  logic             iq_swap;
  logic [LEN_W-1:0] in_block_len;

  // block state
  logic signed [SAMPLE_W-1:0] prev_real, prev_imag;
  logic [LEN_W-1:0]           input_index, input_index_next;
  logic [OIDX_W-1:0]          output_index, output_index_next;
  logic [ACC_W-1:0]           position_acc, position_acc_next;

  // interpolation stage
  logic                       s1_valid;
  logic signed [SAMPLE_W-1:0] s1_base_real, s1_base_imag;
  logic signed [DIFF_W-1:0]   s1_diff_real, s1_diff_imag;
  logic [FRAC_BITS-1:0]       s1_weight;
  logic                       s1_last;

  logic                       in_fire, out_free;
  logic [LEN_W-1:0]           eff_len;
  logic signed [SAMPLE_W-1:0] cur_real, cur_imag;
  logic [BASE_W:0]            base_plus1;
  logic                       emit, wrap;
  logic signed [PROD_W-1:0]   mac_real, mac_imag;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      iq_swap      <= 1'b0;
      in_block_len <= LEN_W'(3072);
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_IQ_SWAP:      iq_swap      <= cfg_data[0];
        REG_IN_BLOCK_LEN: in_block_len <= cfg_data[LEN_W-1:0];
        default:          ;
      endcase
    end
  end

  // handshake
  assign out_free = !out_valid || out_ready;
  assign in_ready = !s1_valid || out_free;
  assign in_fire  = in_valid && in_ready;

  // block length clamped to the supported range
  always_comb begin
    if (in_block_len < LEN_W'(OUT_BLOCK)) begin
      eff_len = LEN_W'(OUT_BLOCK);
    end else if (in_block_len > LEN_W'(MAX_IN_LEN)) begin
      eff_len = LEN_W'(MAX_IN_LEN);
    end else begin
      eff_len = in_block_len;
    end
  end

  // sample word order
  assign cur_real = iq_swap ? in_data.first_word  : in_data.second_word;
  assign cur_imag = iq_swap ? in_data.second_word : in_data.first_word;

  // an output is due when the right neighbour of its pair arrives
  assign base_plus1 = {1'b0, position_acc[ACC_W-1:FRAC_BITS]} + (BASE_W+1)'(1);
  assign emit       = (base_plus1 == (BASE_W+1)'(input_index));
  assign wrap       = (input_index >= eff_len);

  // counter update
  always_comb begin
    output_index_next = output_index;
    position_acc_next = position_acc;
    if (emit) begin
      if (output_index == OIDX_W'(OUT_BLOCK - 1)) begin
        output_index_next = '0;
        position_acc_next = '0;
      end else begin
        output_index_next = output_index + OIDX_W'(1);
        position_acc_next = position_acc + ACC_W'(eff_len);
      end
    end
    if (wrap) begin
      input_index_next  = LEN_W'(1);
      output_index_next = '0;
      position_acc_next = '0;
    end else begin
      input_index_next  = input_index + LEN_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      input_index  <= '0;
      output_index <= '0;
      position_acc <= '0;
      prev_real    <= '0;
      prev_imag    <= '0;
    end else if (in_fire) begin
      input_index  <= input_index_next;
      output_index <= output_index_next;
      position_acc <= position_acc_next;
      prev_real    <= cur_real;
      prev_imag    <= cur_imag;
    end
  end

  // interpolation stage: left sample, difference and weight
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_fire && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_base_real <= prev_real;
      s1_base_imag <= prev_imag;
      s1_diff_real <= DIFF_W'(cur_real) - DIFF_W'(prev_real);
      s1_diff_imag <= DIFF_W'(cur_imag) - DIFF_W'(prev_imag);
      s1_weight    <= position_acc[FRAC_BITS-1:0];
      s1_last      <= (output_index == OIDX_W'(OUT_BLOCK - 1));
    end
  end

  // a * 2^F + (b - a) * w, i.e. a * (2^F - w) + b * w
  assign mac_real = (PROD_W'(s1_base_real) <<< FRAC_BITS)
                  + s1_diff_real * $signed({1'b0, s1_weight});
  assign mac_imag = (PROD_W'(s1_base_imag) <<< FRAC_BITS)
                  + s1_diff_imag * $signed({1'b0, s1_weight});

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && s1_valid) begin
      out_data.out_real   <= mac_real[FRAC_BITS+SAMPLE_W-1:FRAC_BITS];
      out_data.out_imag   <= mac_imag[FRAC_BITS+SAMPLE_W-1:FRAC_BITS];
      out_data.block_last <= s1_last;
    end
  end

  // checks
  a_stage_from_transaction: assert property (@(posedge clk) disable iff (rst)
    $rose(s1_valid) |-> $past(in_valid && in_ready))
    else $error("interpolation stage filled without an input transaction");

  a_wrap_restarts: assert property (@(posedge clk) disable iff (rst)
    (in_fire && wrap) |=> (input_index == LEN_W'(1) && output_index == '0
                           && position_acc == '0))
    else $error("block wrap did not restart the counters");

  a_last_marked: assert property (@(posedge clk) disable iff (rst)
    (in_fire && emit && output_index == OIDX_W'(OUT_BLOCK - 1))
      |=> (s1_valid && s1_last))
    else $error("final output of a block not marked");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !s1_valid |-> in_ready)
    else $error("input stalled with an empty interpolation stage");

endmodule
